>>> design/psag_pkg.sv
package psag_pkg;

   localparam int ADDR_BITS_DEFAULT   = 32;
   localparam int DIM_BITS_DEFAULT    = 12;
   localparam int FACTOR_BITS_DEFAULT = 4;

   localparam int LAYOUT_BITS     = 2;
   localparam int SIZE_BITS       = 13;
   localparam int FACTOR_REG_BITS = 4;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 13;
   localparam int DIMS            = 6;
   localparam int DIM_ID_BITS     = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LAYOUT         = 3'd0,
      REG_BATCHES        = 3'd1,
      REG_HIRES_CHANNELS = 3'd2,
      REG_LOW_HEIGHT     = 3'd3,
      REG_LOW_WIDTH      = 3'd4,
      REG_FACTOR         = 3'd5
   } psag_reg_type;

   typedef enum logic [LAYOUT_BITS-1:0] {
      LAYOUT_SHUFFLE_CONTIG   = 2'd0,
      LAYOUT_SHUFFLE_CLAST    = 2'd1,
      LAYOUT_UNSHUFFLE_CONTIG = 2'd2,
      LAYOUT_UNSHUFFLE_CLAST  = 2'd3
   } psag_layout_type;

   typedef logic [DIM_ID_BITS-1:0] psag_dim_type;

   localparam psag_dim_type DIM_N  = 3'd0;
   localparam psag_dim_type DIM_C  = 3'd1;
   localparam psag_dim_type DIM_H  = 3'd2;
   localparam psag_dim_type DIM_W  = 3'd3;
   localparam psag_dim_type DIM_S1 = 3'd4;
   localparam psag_dim_type DIM_S2 = 3'd5;

   typedef struct packed {
      logic         busy;
      logic         load;
      psag_dim_type dim;
   } psag_seq_type;

   // position 0 is the outermost loop
   function automatic psag_dim_type loop_dim(input psag_layout_type layout,
                                             input logic [DIM_ID_BITS-1:0] pos);
      logic [DIMS-1:0][DIM_ID_BITS-1:0] order;
      unique case (layout)
         LAYOUT_SHUFFLE_CONTIG:   order = {DIM_S2, DIM_W, DIM_S1, DIM_H, DIM_C, DIM_N};
         LAYOUT_SHUFFLE_CLAST:    order = {DIM_C, DIM_S2, DIM_W, DIM_S1, DIM_H, DIM_N};
         LAYOUT_UNSHUFFLE_CONTIG: order = {DIM_W, DIM_H, DIM_S2, DIM_S1, DIM_C, DIM_N};
         default:                 order = {DIM_S2, DIM_S1, DIM_C, DIM_W, DIM_H, DIM_N};
      endcase
      return order[pos];
   endfunction

endpackage

>>> design/pixel_shuffle_address_generator.sv
// Each response is registered and appears in the cycle after its request transfer.
// Throughput: one address per cycle with rsp_ready high and no csr write or rebuild.
// After reset and after every csr write, strides and per-dimension offsets are rebuilt
// on one shared multiplier, stride products first, with req_ready low.
// Reset is synchronous: counters clear and the csr registers load their default values.
module pixel_shuffle_address_generator #(
   parameter int ADDR_BITS   = psag_pkg::ADDR_BITS_DEFAULT,
   parameter int DIM_BITS    = psag_pkg::DIM_BITS_DEFAULT,
   parameter int FACTOR_BITS = psag_pkg::FACTOR_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ADDR_BITS-1:0]                  rsp_source_offset,
   output logic                                  rsp_last,
   input  logic                                  csr_wen,
   input  logic [psag_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [psag_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import psag_pkg::*;

   localparam int CNT_BITS = ((DIM_BITS > FACTOR_BITS) ? DIM_BITS : FACTOR_BITS) + 1;
   localparam int SIZE_CMP = (SIZE_BITS > DIM_BITS + 1) ? SIZE_BITS : DIM_BITS + 1;
   localparam int FAC_CMP  = (FACTOR_REG_BITS > FACTOR_BITS + 1) ?
                             FACTOR_REG_BITS : FACTOR_BITS + 1;
   localparam logic [SIZE_CMP-1:0] DIM_MAX = SIZE_CMP'(1) << DIM_BITS;
   localparam logic [FAC_CMP-1:0]  FAC_MAX = FAC_CMP'(1) << FACTOR_BITS;

   function automatic logic [CNT_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v);
      logic [SIZE_CMP-1:0] x;
      x = SIZE_CMP'(v);
      if (v == '0) begin
         return CNT_BITS'(1);
      end else if (x > DIM_MAX) begin
         return CNT_BITS'(DIM_MAX);
      end
      return CNT_BITS'(x);
   endfunction

   function automatic logic [CNT_BITS-1:0] clamp_factor(input logic [FACTOR_REG_BITS-1:0] v);
      logic [FAC_CMP-1:0] x;
      x = FAC_CMP'(v);
      if (v == '0) begin
         return CNT_BITS'(1);
      end else if (x > FAC_MAX) begin
         return CNT_BITS'(FAC_MAX);
      end
      return CNT_BITS'(x);
   endfunction

   psag_layout_type               layout_ff;
   logic [SIZE_BITS-1:0]          batches_ff, hires_channels_ff, low_height_ff, low_width_ff;
   logic [FACTOR_REG_BITS-1:0]    factor_ff;

   logic [DIM_BITS-1:0]           dim_cnt_ff [4];
   logic [FACTOR_BITS-1:0]        sub_cnt_ff [2];
   logic [ADDR_BITS-1:0]          contrib_ff [DIMS];

   logic                          rsp_valid_ff;
   logic [ADDR_BITS-1:0]          rsp_offset_ff, rsp_offset_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [DIMS-1:0][CNT_BITS-1:0]  ext, cnt_raw, cnt_w, cnt_in;
   logic [DIMS-1:0][ADDR_BITS-1:0] str, contrib_w, contrib_in;
   logic [DIMS-1:0]                at, carry_in;
   psag_seq_type                   seq;
   logic [ADDR_BITS-1:0]           load_value;
   logic                           accept;

   assign ext[DIM_N]  = clamp_size(batches_ff);
   assign ext[DIM_C]  = clamp_size(hires_channels_ff);
   assign ext[DIM_H]  = clamp_size(low_height_ff);
   assign ext[DIM_W]  = clamp_size(low_width_ff);
   assign ext[DIM_S1] = clamp_factor(factor_ff);
   assign ext[DIM_S2] = clamp_factor(factor_ff);

   assign cnt_raw[DIM_N]  = CNT_BITS'(dim_cnt_ff[0]);
   assign cnt_raw[DIM_C]  = CNT_BITS'(dim_cnt_ff[1]);
   assign cnt_raw[DIM_H]  = CNT_BITS'(dim_cnt_ff[2]);
   assign cnt_raw[DIM_W]  = CNT_BITS'(dim_cnt_ff[3]);
   assign cnt_raw[DIM_S1] = CNT_BITS'(sub_cnt_ff[0]);
   assign cnt_raw[DIM_S2] = CNT_BITS'(sub_cnt_ff[1]);

   psag_stride_seq #(
      .ADDR_BITS   (ADDR_BITS),
      .DIM_BITS    (DIM_BITS),
      .FACTOR_BITS (FACTOR_BITS),
      .CNT_BITS    (CNT_BITS)
   ) u_stride_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_wen),
      .layout     (layout_ff),
      .ext        (ext),
      .cnt        (cnt_raw),
      .str        (str),
      .seq        (seq),
      .load_value (load_value)
   );

   assign req_ready = !seq.busy && !csr_wen && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      psag_dim_type d;
      logic         carry;
      carry         = 1'b1;
      rsp_offset_in = '0;
      for (int k = 0; k < DIMS; k++) begin
         cnt_w[k]     = req_restart ? '0 : cnt_raw[k];
         contrib_w[k] = req_restart ? '0 : contrib_ff[k];
         at[k]        = (cnt_w[k] + CNT_BITS'(1)) >= ext[k];
         rsp_offset_in = rsp_offset_in + contrib_w[k];
      end
      carry_in = '0;
      for (int k = DIMS - 1; k >= 0; k--) begin
         d = loop_dim(layout_ff, DIM_ID_BITS'(k));
         carry_in[d] = carry;
         carry = carry & at[d];
      end
      for (int k = 0; k < DIMS; k++) begin
         cnt_in[k]     = cnt_w[k];
         contrib_in[k] = contrib_w[k];
         if (carry_in[k]) begin
            if (at[k]) begin
               cnt_in[k]     = '0;
               contrib_in[k] = '0;
            end else begin
               cnt_in[k]     = cnt_w[k] + CNT_BITS'(1);
               contrib_in[k] = contrib_w[k] + str[k];
            end
         end
      end
      rsp_last_in = &at;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff         <= LAYOUT_SHUFFLE_CONTIG;
         batches_ff        <= SIZE_BITS'(1);
         hires_channels_ff <= SIZE_BITS'(1);
         low_height_ff     <= SIZE_BITS'(1);
         low_width_ff      <= SIZE_BITS'(1);
         factor_ff         <= FACTOR_REG_BITS'(2);
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_LAYOUT:         layout_ff <= psag_layout_type'(csr_wdata[LAYOUT_BITS-1:0]);
            REG_BATCHES:        batches_ff        <= csr_wdata;
            REG_HIRES_CHANNELS: hires_channels_ff <= csr_wdata;
            REG_LOW_HEIGHT:     low_height_ff     <= csr_wdata;
            REG_LOW_WIDTH:      low_width_ff      <= csr_wdata;
            REG_FACTOR:         factor_ff         <= csr_wdata[FACTOR_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            dim_cnt_ff[k] <= '0;
         end
         for (int k = 0; k < 2; k++) begin
            sub_cnt_ff[k] <= '0;
         end
      end else if (accept) begin
         dim_cnt_ff[0] <= cnt_in[DIM_N][DIM_BITS-1:0];
         dim_cnt_ff[1] <= cnt_in[DIM_C][DIM_BITS-1:0];
         dim_cnt_ff[2] <= cnt_in[DIM_H][DIM_BITS-1:0];
         dim_cnt_ff[3] <= cnt_in[DIM_W][DIM_BITS-1:0];
         sub_cnt_ff[0] <= cnt_in[DIM_S1][FACTOR_BITS-1:0];
         sub_cnt_ff[1] <= cnt_in[DIM_S2][FACTOR_BITS-1:0];
      end
   end

   // rebuild offsets from the sequencer, step them on each transfer
   always_ff @(posedge clock) begin
      if (seq.load) begin
         contrib_ff[seq.dim] <= load_value;
      end else if (accept) begin
         for (int k = 0; k < DIMS; k++) begin
            contrib_ff[k] <= contrib_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_offset_ff <= rsp_offset_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_source_offset = rsp_offset_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

>>> design/psag_stride_seq.sv
module psag_stride_seq #(
   parameter int ADDR_BITS   = psag_pkg::ADDR_BITS_DEFAULT,
   parameter int DIM_BITS    = psag_pkg::DIM_BITS_DEFAULT,
   parameter int FACTOR_BITS = psag_pkg::FACTOR_BITS_DEFAULT,
   parameter int CNT_BITS    = ((DIM_BITS > FACTOR_BITS) ? DIM_BITS : FACTOR_BITS) + 1
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_write,
   input  psag_pkg::psag_layout_type                  layout,
   input  logic [psag_pkg::DIMS-1:0][CNT_BITS-1:0]    ext,
   input  logic [psag_pkg::DIMS-1:0][CNT_BITS-1:0]    cnt,
   output logic [psag_pkg::DIMS-1:0][ADDR_BITS-1:0]   str,
   output psag_pkg::psag_seq_type                     seq,
   output logic [ADDR_BITS-1:0]                       load_value
);
   import psag_pkg::*;

   localparam int PRODS     = 12;
   localparam int STEPS     = PRODS + DIMS;
   localparam int STEP_BITS = $clog2(STEPS);

   localparam logic [STEP_BITS-1:0] ST_SS    = STEP_BITS'(0);
   localparam logic [STEP_BITS-1:0] ST_HW    = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] ST_SHW   = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] ST_SSHW  = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] ST_CH    = STEP_BITS'(4);
   localparam logic [STEP_BITS-1:0] ST_CHW   = STEP_BITS'(5);
   localparam logic [STEP_BITS-1:0] ST_WCH   = STEP_BITS'(6);
   localparam logic [STEP_BITS-1:0] ST_SSW   = STEP_BITS'(7);
   localparam logic [STEP_BITS-1:0] ST_WS    = STEP_BITS'(8);
   localparam logic [STEP_BITS-1:0] ST_SC    = STEP_BITS'(9);
   localparam logic [STEP_BITS-1:0] ST_WSC   = STEP_BITS'(10);
   localparam logic [STEP_BITS-1:0] ST_SSWC  = STEP_BITS'(11);
   localparam logic [STEP_BITS-1:0] ST_CONTRIB_FIRST = STEP_BITS'(PRODS);
   localparam logic [STEP_BITS-1:0] ST_LAST  = STEP_BITS'(STEPS - 1);

   logic                  busy_ff, busy_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;

   logic [ADDR_BITS-1:0]  ss_ff, hw_ff, shw_ff, sshw_ff, ch_ff, chw_ff;
   logic [ADDR_BITS-1:0]  wch_ff, ssw_ff, ws_ff, sc_ff, wsc_ff, sswc_ff;

   logic [ADDR_BITS-1:0]           mul_a;
   logic [CNT_BITS-1:0]            mul_b;
   logic [ADDR_BITS-1:0]           mul_lo;
   psag_dim_type                   contrib_dim;

   logic [CNT_BITS-1:0] s_ext, c_ext, h_ext, w_ext;
   logic [ADDR_BITS-1:0] s_addr, c_addr, h_addr, w_addr, one_addr;

   assign s_ext  = ext[DIM_S1];
   assign c_ext  = ext[DIM_C];
   assign h_ext  = ext[DIM_H];
   assign w_ext  = ext[DIM_W];
   assign s_addr = ADDR_BITS'(s_ext);
   assign c_addr = ADDR_BITS'(c_ext);
   assign h_addr = ADDR_BITS'(h_ext);
   assign w_addr = ADDR_BITS'(w_ext);
   assign one_addr = ADDR_BITS'(1);

   assign contrib_dim = psag_dim_type'(step_ff - ST_CONTRIB_FIRST);

   always_comb begin
      str = '0;
      str[DIM_N] = chw_ff;
      unique case (layout)
         LAYOUT_SHUFFLE_CONTIG: begin
            str[DIM_C]  = sshw_ff;
            str[DIM_H]  = w_addr;
            str[DIM_W]  = one_addr;
            str[DIM_S1] = shw_ff;
            str[DIM_S2] = hw_ff;
         end
         LAYOUT_SHUFFLE_CLAST: begin
            str[DIM_C]  = ss_ff;
            str[DIM_H]  = wch_ff;
            str[DIM_W]  = ch_ff;
            str[DIM_S1] = s_addr;
            str[DIM_S2] = one_addr;
         end
         LAYOUT_UNSHUFFLE_CONTIG: begin
            str[DIM_C]  = sshw_ff;
            str[DIM_H]  = ssw_ff;
            str[DIM_W]  = s_addr;
            str[DIM_S1] = ws_ff;
            str[DIM_S2] = one_addr;
         end
         default: begin
            str[DIM_C]  = one_addr;
            str[DIM_H]  = sswc_ff;
            str[DIM_W]  = sc_ff;
            str[DIM_S1] = wsc_ff;
            str[DIM_S2] = c_addr;
         end
      endcase
   end

   always_comb begin
      unique case (step_ff)
         ST_SS:   begin mul_a = s_addr;  mul_b = s_ext; end
         ST_HW:   begin mul_a = h_addr;  mul_b = w_ext; end
         ST_SHW:  begin mul_a = hw_ff;   mul_b = s_ext; end
         ST_SSHW: begin mul_a = shw_ff;  mul_b = s_ext; end
         ST_CH:   begin mul_a = ss_ff;   mul_b = c_ext; end
         ST_CHW:  begin mul_a = sshw_ff; mul_b = c_ext; end
         ST_WCH:  begin mul_a = ch_ff;   mul_b = w_ext; end
         ST_SSW:  begin mul_a = ss_ff;   mul_b = w_ext; end
         ST_WS:   begin mul_a = w_addr;  mul_b = s_ext; end
         ST_SC:   begin mul_a = c_addr;  mul_b = s_ext; end
         ST_WSC:  begin mul_a = ws_ff;   mul_b = c_ext; end
         ST_SSWC: begin mul_a = wsc_ff;  mul_b = s_ext; end
         default: begin mul_a = str[contrib_dim]; mul_b = cnt[contrib_dim]; end
      endcase
   end

   assign mul_lo     = mul_a * ADDR_BITS'(mul_b);
   assign load_value = mul_lo;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (csr_write) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         if (step_ff == ST_LAST) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         unique case (step_ff)
            ST_SS:   ss_ff   <= mul_lo;
            ST_HW:   hw_ff   <= mul_lo;
            ST_SHW:  shw_ff  <= mul_lo;
            ST_SSHW: sshw_ff <= mul_lo;
            ST_CH:   ch_ff   <= mul_lo;
            ST_CHW:  chw_ff  <= mul_lo;
            ST_WCH:  wch_ff  <= mul_lo;
            ST_SSW:  ssw_ff  <= mul_lo;
            ST_WS:   ws_ff   <= mul_lo;
            ST_SC:   sc_ff   <= mul_lo;
            ST_WSC:  wsc_ff  <= mul_lo;
            ST_SSWC: sswc_ff <= mul_lo;
            default: ;
         endcase
      end
   end

   assign seq.busy = busy_ff;
   assign seq.load = busy_ff && (step_ff >= ST_CONTRIB_FIRST);
   assign seq.dim  = contrib_dim;

endmodule

>>> tb/sv/tb_pixel_shuffle_address_generator.sv
module tb_pixel_shuffle_address_generator;

   import psag_pkg::*;

   localparam int              ADDR_W            = ADDR_BITS_DEFAULT;
   localparam longint unsigned DIM_LIMIT         = 64'd1 << DIM_BITS_DEFAULT;
   localparam longint unsigned FACTOR_LIMIT      = 64'd1 << FACTOR_BITS_DEFAULT;
   localparam int              RANDOM_ITEMS      = 1780;
   localparam int              LONG_HOLD_CYCLES  = 300;
   localparam int              DRAIN_TAIL_CYCLES = 20;
   localparam int              CYCLE_LIMIT       = 400000;

   localparam logic [CSR_INDEX_BITS-1:0] REG_INDEX_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INDEX_SPARE_HI = 3'd7;

   // innermost loop last
   localparam psag_dim_type walk_order [4][DIMS] = '{
      '{DIM_N, DIM_C, DIM_H, DIM_S1, DIM_W, DIM_S2},
      '{DIM_N, DIM_H, DIM_S1, DIM_W, DIM_S2, DIM_C},
      '{DIM_N, DIM_C, DIM_S1, DIM_S2, DIM_H, DIM_W},
      '{DIM_N, DIM_H, DIM_W, DIM_C, DIM_S1, DIM_S2}
   };

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic              last;
   } source_address_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic                      req_restart = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic [ADDR_W-1:0]         rsp_source_offset;
   logic                      rsp_last;
   logic                      csr_wen     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata   = '0;

   psag_layout_type        cfg_layout         = LAYOUT_SHUFFLE_CONTIG;
   logic [SIZE_BITS-1:0]   cfg_batches        = 13'd1;
   logic [SIZE_BITS-1:0]   cfg_hires_channels = 13'd1;
   logic [SIZE_BITS-1:0]   cfg_low_height     = 13'd1;
   logic [SIZE_BITS-1:0]   cfg_low_width      = 13'd1;
   logic [FACTOR_REG_BITS-1:0] cfg_factor     = 4'd2;

   longint unsigned walk_pos [DIMS] = '{default: 0};
   source_address_type expected_addresses [$];

   int error_count     = 0;
   int cycle_count     = 0;
   int burst_left      = 0;
   int holds_requested = 0;
   int holds_served    = 0;

   pixel_shuffle_address_generator u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_source_offset (rsp_source_offset),
      .rsp_last          (rsp_last),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count <= CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("pixel_shuffle_address_generator test failed");
      $finish;
   end

   function automatic longint unsigned clamp_extent(input longint unsigned v,
                                                    input longint unsigned top);
      if (v == 0) return 1;
      return (v > top) ? top : v;
   endfunction

   function automatic longint unsigned tensor_elements();
      longint unsigned s;
      s = clamp_extent(cfg_factor, FACTOR_LIMIT);
      return clamp_extent(cfg_batches, DIM_LIMIT) * clamp_extent(cfg_hires_channels, DIM_LIMIT)
           * clamp_extent(cfg_low_height, DIM_LIMIT) * clamp_extent(cfg_low_width, DIM_LIMIT)
           * s * s;
   endfunction

   task automatic predict_source_offset(input logic restart);
      longint unsigned ext [DIMS];
      longint unsigned stride [DIMS];
      longint unsigned c, h, w, s, ch, offset;
      psag_dim_type    d;
      logic            at_end, carry;
      source_address_type r;
      if (restart) begin
         foreach (walk_pos[k]) walk_pos[k] = 0;
      end
      ext[DIM_N] = clamp_extent(cfg_batches, DIM_LIMIT);
      c = clamp_extent(cfg_hires_channels, DIM_LIMIT);
      h = clamp_extent(cfg_low_height, DIM_LIMIT);
      w = clamp_extent(cfg_low_width, DIM_LIMIT);
      s = clamp_extent(cfg_factor, FACTOR_LIMIT);
      ext[DIM_C]  = c;
      ext[DIM_H]  = h;
      ext[DIM_W]  = w;
      ext[DIM_S1] = s;
      ext[DIM_S2] = s;
      ch = c * s * s;
      case (cfg_layout)
         LAYOUT_SHUFFLE_CONTIG: begin
            stride[DIM_N]  = ch * h * w;
            stride[DIM_C]  = s * s * h * w;
            stride[DIM_S1] = s * h * w;
            stride[DIM_S2] = h * w;
            stride[DIM_H]  = w;
            stride[DIM_W]  = 1;
         end
         LAYOUT_SHUFFLE_CLAST: begin
            stride[DIM_N]  = h * w * ch;
            stride[DIM_H]  = w * ch;
            stride[DIM_W]  = ch;
            stride[DIM_C]  = s * s;
            stride[DIM_S1] = s;
            stride[DIM_S2] = 1;
         end
         LAYOUT_UNSHUFFLE_CONTIG: begin
            stride[DIM_N]  = ch * h * w;
            stride[DIM_C]  = h * s * w * s;
            stride[DIM_H]  = s * w * s;
            stride[DIM_S1] = w * s;
            stride[DIM_W]  = s;
            stride[DIM_S2] = 1;
         end
         default: begin
            stride[DIM_N]  = h * w * ch;
            stride[DIM_H]  = s * w * s * c;
            stride[DIM_S1] = w * s * c;
            stride[DIM_W]  = s * c;
            stride[DIM_S2] = c;
            stride[DIM_C]  = 1;
         end
      endcase
      offset = 0;
      at_end = 1'b1;
      for (int k = 0; k < DIMS; k++) begin
         offset += walk_pos[k] * stride[k];
         if (walk_pos[k] + 1 < ext[k]) at_end = 1'b0;
      end
      carry = 1'b1;
      for (int k = DIMS - 1; k >= 0; k--) begin
         if (carry) begin
            d = walk_order[cfg_layout][k];
            if (walk_pos[d] + 1 >= ext[d]) begin
               walk_pos[d] = 0;
            end else begin
               walk_pos[d]++;
               carry = 1'b0;
            end
         end
      end
      r.offset = offset[ADDR_W-1:0];
      r.last   = at_end;
      expected_addresses.push_back(r);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
      case (index)
         REG_LAYOUT:         cfg_layout         = psag_layout_type'(data[LAYOUT_BITS-1:0]);
         REG_BATCHES:        cfg_batches        = data[SIZE_BITS-1:0];
         REG_HIRES_CHANNELS: cfg_hires_channels = data[SIZE_BITS-1:0];
         REG_LOW_HEIGHT:     cfg_low_height     = data[SIZE_BITS-1:0];
         REG_LOW_WIDTH:      cfg_low_width      = data[SIZE_BITS-1:0];
         REG_FACTOR:         cfg_factor         = data[FACTOR_REG_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic send_request(input logic restart);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_source_offset(restart);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (expected_addresses.size() != 0);
   endtask

   task automatic write_shape(input psag_layout_type layout,
                              input logic [SIZE_BITS-1:0] batches, hires_channels,
                              input logic [SIZE_BITS-1:0] low_height, low_width,
                              input logic [FACTOR_REG_BITS-1:0] factor);
      write_register(REG_LAYOUT, CSR_DATA_BITS'(layout));
      write_register(REG_BATCHES, batches);
      write_register(REG_HIRES_CHANNELS, hires_channels);
      write_register(REG_LOW_HEIGHT, low_height);
      write_register(REG_LOW_WIDTH, low_width);
      write_register(REG_FACTOR, CSR_DATA_BITS'(factor));
   endtask

   function automatic logic [SIZE_BITS-1:0] pick_size();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 16) return SIZE_BITS'($urandom_range(1, 3));
      if (pick == 16) return '0;
      if (pick == 17) return SIZE_BITS'(DIM_LIMIT);
      if (pick == 18) return '1;
      return SIZE_BITS'($urandom_range(0, 8191));
   endfunction

   function automatic logic [FACTOR_REG_BITS-1:0] pick_factor();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 16) return FACTOR_REG_BITS'($urandom_range(1, 3));
      if (pick == 16) return '0;
      if (pick == 17) return '1;
      return FACTOR_REG_BITS'($urandom_range(0, 15));
   endfunction

   always @(posedge clock) begin : check_responses
      source_address_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_addresses.size() == 0) begin
            $display("%0t: unexpected response, expected none actual offset %h last %b",
                     $time, rsp_source_offset, rsp_last);
            error_count++;
         end else begin
            want = expected_addresses.pop_front();
            if (rsp_source_offset !== want.offset) begin
               $display("%0t: source_offset mismatch, expected %h actual %h",
                        $time, want.offset, rsp_source_offset);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch, expected %b actual %b",
                        $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin : response_sink
      int seg_len, mode;
      forever begin
         if (holds_served < holds_requested) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            holds_served++;
         end else begin
            seg_len = $urandom_range(4, 60);
            mode = $urandom_range(0, 3);
            repeat (seg_len) begin
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= ($urandom_range(0, 3) != 0);
                  2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= ~rsp_ready;
               endcase
               @(negedge clock);
            end
         end
      end
   end

   task automatic test_reset_defaults();
      repeat (5) send_request(1'b0);
   endtask

   task automatic test_each_layout();
      psag_layout_type layouts [4];
      layouts = '{LAYOUT_SHUFFLE_CONTIG, LAYOUT_SHUFFLE_CLAST,
                  LAYOUT_UNSHUFFLE_CONTIG, LAYOUT_UNSHUFFLE_CLAST};
      foreach (layouts[i]) begin
         drain_results();
         write_register(REG_LAYOUT, CSR_DATA_BITS'(layouts[i]));
         send_request(1'b1);
         repeat (2) send_request(1'b0);
      end
   endtask

   task automatic test_zero_sizes();
      drain_results();
      write_shape(LAYOUT_SHUFFLE_CLAST, '0, '0, '0, '0, '0);
      repeat (2) send_request(1'b0);
   endtask

   task automatic test_oversized_sizes();
      drain_results();
      write_shape(LAYOUT_UNSHUFFLE_CLAST, '1, 13'd4097, SIZE_BITS'(DIM_LIMIT), '1, '1);
      send_request(1'b1);
      repeat (2) send_request(1'b0);
   endtask

   task automatic test_midtensor_reconfig();
      drain_results();
      write_shape(LAYOUT_SHUFFLE_CONTIG, 13'd1, 13'd1, 13'd1, 13'd3, 4'd1);
      send_request(1'b1);
      send_request(1'b0);
      drain_results();
      write_register(REG_LOW_WIDTH, 13'd1);
      repeat (2) send_request(1'b0);
   endtask

   task automatic test_spare_register_index();
      drain_results();
      write_register(REG_INDEX_SPARE_LO, '1);
      write_register(REG_INDEX_SPARE_HI, '1);
      send_request(1'b0);
   endtask

   task automatic test_backpressure();
      drain_results();
      write_shape(LAYOUT_UNSHUFFLE_CONTIG, 13'd2, 13'd2, 13'd2, 13'd3, 4'd2);
      holds_requested++;
      send_request(1'b1);
      repeat (79) send_request($urandom_range(0, 29) == 0);
      drain_results();
   endtask

   task automatic test_random_tensors();
      int              sent, count, phase;
      longint unsigned total;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         drain_results();
         if ($urandom_range(0, 3) == 0) begin
            write_register(CSR_INDEX_BITS'($urandom_range(0, 7)),
                           CSR_DATA_BITS'($urandom_range(0, 8191)));
         end else begin
            write_register(REG_LAYOUT, CSR_DATA_BITS'($urandom_range(0, 8191)));
            write_register(REG_BATCHES, pick_size());
            write_register(REG_HIRES_CHANNELS, pick_size());
            write_register(REG_LOW_HEIGHT, pick_size());
            write_register(REG_LOW_WIDTH, pick_size());
            write_register(REG_FACTOR, {9'($urandom_range(0, 511)), pick_factor()});
            if ($urandom_range(0, 4) == 0) begin
               write_register($urandom_range(0, 1) ? REG_INDEX_SPARE_HI : REG_INDEX_SPARE_LO,
                              CSR_DATA_BITS'($urandom_range(0, 8191)));
            end
         end
         if (phase % 8 == 7) holds_requested++;
         total = tensor_elements();
         if (total <= 300 && $urandom_range(0, 4) != 0) begin
            count = int'(total) * ($urandom_range(1, 2) + ((total < 16) ? 3 : 0));
            send_request(1'b1);
            repeat (count - 1) send_request($urandom_range(0, 49) == 0);
         end else begin
            count = $urandom_range(16, 80);
            repeat (count) send_request($urandom_range(0, 19) == 0);
         end
         sent += count;
         phase++;
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_each_layout();
      test_zero_sizes();
      test_oversized_sizes();
      test_midtensor_reconfig();
      test_spare_register_index();
      test_backpressure();
      test_random_tensors();
      drain_results();
      repeat (DRAIN_TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_addresses.size() == 0) begin
         $display("pixel_shuffle_address_generator test passed");
      end else begin
         $display("pixel_shuffle_address_generator test failed");
      end
      $finish;
   end

endmodule
